// ----- design/dmx_pkg.sv -----
// dmx_pkg: shared types, codes and constants for the DNS MX answer parser.
// Used by dmx_ctrl, dmx_datapath and dns_mx_answer_parser. No dependencies.
package dmx_pkg;

  localparam int unsigned PACKET_BYTES_DEF = 512;
  localparam int unsigned NAME_BYTES_DEF   = 256;
  localparam int unsigned MAX_RECORDS_DEF  = 16;
  localparam int unsigned MAX_HOPS_DEF     = 16;

  // position width: covers packet offsets plus a 16-bit rdata length
  localparam int unsigned POS_W      = 18;
  localparam int unsigned HEADER_LEN = 12;
  localparam int unsigned RR_FIXED   = 10;

  localparam logic [15:0] TYPE_MX    = 16'd15;
  localparam logic [15:0] TYPE_CNAME = 16'd5;
  localparam logic [7:0]  CHAR_DOT   = 8'h2E;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PARSE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] KIND_MX     = 2'd0;
  localparam logic [1:0] KIND_CNAME  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;
  localparam logic [1:0] KIND_BYTE   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_RCODE     = 3'd2;
  localparam logic [2:0] ST_NO_ANS    = 3'd3;
  localparam logic [2:0] ST_BAD_QUEST = 3'd4;
  localparam logic [2:0] ST_BAD_ANS   = 3'd5;
  localparam logic [2:0] ST_OTHER     = 3'd6;
  localparam logic [2:0] ST_NAME_ERR  = 3'd7;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_INIT, OP_SET_CNT, OP_SKIP_BEGIN, OP_LEN, OP_SKIP_NEXT,
    OP_SKIP_PTR_END, OP_SKIP_ZERO_END, OP_Q_END, OP_TYPE, OP_TTL, OP_RDLEN,
    OP_DEC_MX, OP_DEC_CN, OP_PTR, OP_COPY_WR, OP_DOT, OP_DEC_END, OP_EMIT_MX,
    OP_EMIT_CN, OP_FINISH, OP_NAME_RD, OP_NAME_OUT
  } dp_op_e;

  typedef enum logic [1:0] {
    BASE_ZERO, BASE_POS, BASE_P, BASE_COPY
  } rd_base_e;

  typedef struct packed {
    dp_op_e     op;
    logic       shift;
    rd_base_e   base;
    logic [3:0] off;
    logic [2:0] st;
  } cmd_t;

  typedef struct packed {
    logic short_pkt;
    logic rcode_bad;
    logic an_hdr_zero;
    logic qd_zero;
    logic an_zero;
    logic p_ge_n;
    logic p1_ge_n;
    logic p2_ge_n;
    logic top_ptr;
    logic top_bad;
    logic byte_zero;
    logic pos4_ge_n;
    logic pos10_ge_n;
    logic mx_bad;
    logic type_mx;
    logic type_cname;
    logic hops_over;
    logic label_bad;
    logic copy_last;
  } flags_t;

endpackage

// ----- design/dmx_datapath.sv -----
// dmx_datapath: packet and name memories, parse registers and result registers.
// Executes one dmx_pkg::cmd_t per cycle and reports dmx_pkg::flags_t.
module dmx_datapath #(
  parameter int unsigned PACKET_BYTES = 512,
  parameter int unsigned NAME_BYTES   = 256,
  parameter int unsigned MAX_RECORDS  = 16,
  parameter int unsigned MAX_HOPS     = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dmx_pkg::cmd_t  cmd_i,
  output dmx_pkg::flags_t flags_o,
  input  logic [7:0]     packet_byte_i,
  input  logic [4:0]     record_select_i,
  input  logic [7:0]     char_index_i,
  output logic           result_valid_o,
  output logic [1:0]     kind_o,
  output logic [15:0]    preference_o,
  output logic [31:0]    ttl_o,
  output logic [8:0]     name_length_o,
  output logic [4:0]     slot_o,
  output logic [2:0]     status_o,
  output logic [7:0]     name_byte_o,
  output logic           last_o
);
  import dmx_pkg::*;

  localparam int unsigned AW    = $clog2(PACKET_BYTES);
  localparam int unsigned CW    = $clog2(PACKET_BYTES + 1);
  localparam int unsigned NIW   = $clog2(NAME_BYTES);
  localparam int unsigned NLW   = $clog2(NAME_BYTES + 1);
  localparam int unsigned RW    = $clog2(MAX_RECORDS + 1);
  localparam int unsigned HW    = $clog2(MAX_HOPS + 1);
  localparam int unsigned SLOTS = MAX_RECORDS + 1;
  localparam int unsigned NDEP  = SLOTS * (2 ** NIW);

  logic [7:0]       pkt_mem [PACKET_BYTES];
  logic [7:0]       name_mem [NDEP];

  logic [CW-1:0]    cnt_q;
  logic [RW-1:0]    total_q;
  logic [NLW-1:0]   lengths_q [SLOTS];
  logic             strobe_q;

  logic [7:0]       pkt_q;
  logic [7:0]       nm_q;
  logic [31:0]      sh_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] p_q;
  logic [7:0]       len_q;
  logic [7:0]       ci_q;
  logic [NLW-1:0]   written_q;
  logic [NLW-1:0]   wlen_q;
  logic [HW-1:0]    hops_q;
  logic [15:0]      qd_q;
  logic [15:0]      an_q;
  logic [15:0]      type_q;
  logic [15:0]      rdlen_q;
  logic [15:0]      pref_q;
  logic [31:0]      ttl_q;
  logic             keep_q;
  logic [RW-1:0]    wslot_q;
  logic [4:0]       rsel_q;
  logic [NLW-1:0]   rlen_q;
  logic             rok_q;

  logic [1:0]       kind_q;
  logic [15:0]      pref_out_q;
  logic [31:0]      ttl_out_q;
  logic [8:0]       nlen_q;
  logic [4:0]       slot_q;
  logic [2:0]       status_q;
  logic [7:0]       nbyte_q;
  logic             last_q;

  logic [POS_W-1:0] n;
  logic [POS_W-1:0] base;
  logic [POS_W-1:0] rd_addr;
  logic             pkt_we;
  logic             nm_we;
  logic [NLW-1:0]   nm_widx;
  logic [7:0]       nm_wdata;
  logic [RW+NIW-1:0] nm_waddr;
  logic [RW+NIW-1:0] nm_raddr;
  logic             sel_ok;
  logic             emit;

  assign n = POS_W'(cnt_q);

  always_comb begin
    unique case (cmd_i.base)
      BASE_ZERO: base = '0;
      BASE_POS:  base = pos_q;
      BASE_P:    base = p_q;
      BASE_COPY: base = p_q + POS_W'(ci_q) + POS_W'(1);
      default:   base = '0;
    endcase
    rd_addr = base + POS_W'(cmd_i.off);
  end

  assign pkt_we = (cmd_i.op == OP_LOAD) && (cnt_q < CW'(PACKET_BYTES));

  always_ff @(posedge clk_i) begin
    if (pkt_we) pkt_mem[cnt_q[AW-1:0]] <= packet_byte_i;
    pkt_q <= pkt_mem[rd_addr[AW-1:0]];
  end

  always_comb begin
    nm_we    = 1'b0;
    nm_widx  = written_q;
    nm_wdata = pkt_q;
    unique case (cmd_i.op)
      OP_COPY_WR: nm_we = keep_q;
      OP_DOT: begin
        nm_we    = keep_q;
        nm_wdata = CHAR_DOT;
      end
      OP_DEC_END: begin
        nm_we    = keep_q;
        nm_wdata = 8'h00;
        nm_widx  = (written_q == '0) ? '0 : written_q - NLW'(1);
      end
      default: ;
    endcase
  end

  assign nm_waddr = {wslot_q, NIW'(nm_widx)};
  assign nm_raddr = {RW'(record_select_i), NIW'(char_index_i)};
  assign sel_ok   = 32'(record_select_i) <= MAX_RECORDS;

  always_ff @(posedge clk_i) begin
    if (nm_we) name_mem[nm_waddr] <= nm_wdata;
    nm_q <= name_mem[nm_raddr];
  end

  assign emit = ((cmd_i.op == OP_EMIT_MX) && keep_q) || (cmd_i.op == OP_EMIT_CN) ||
                (cmd_i.op == OP_FINISH) || (cmd_i.op == OP_NAME_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      total_q   <= '0;
      lengths_q <= '{default: '0};
      strobe_q  <= 1'b0;
    end else begin
      strobe_q <= emit;
      if (pkt_we) cnt_q <= cnt_q + CW'(1);
      if (cmd_i.op == OP_INIT) begin
        total_q   <= '0;
        lengths_q <= '{default: '0};
      end
      if ((cmd_i.op == OP_EMIT_MX) && keep_q) begin
        lengths_q[wslot_q] <= wlen_q;
        total_q            <= total_q + RW'(1);
      end
      if (cmd_i.op == OP_EMIT_CN) lengths_q[MAX_RECORDS] <= wlen_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) sh_q <= {sh_q[23:0], pkt_q};
    unique case (cmd_i.op)
      OP_INIT:          pos_q <= POS_W'(HEADER_LEN);
      OP_SET_CNT: begin
        qd_q <= sh_q[31:16];
        an_q <= sh_q[15:0];
      end
      OP_SKIP_BEGIN:    p_q <= pos_q;
      OP_LEN:           len_q <= pkt_q;
      OP_SKIP_NEXT:     p_q <= p_q + POS_W'(len_q) + POS_W'(1);
      OP_SKIP_PTR_END:  pos_q <= p_q + POS_W'(2);
      OP_SKIP_ZERO_END: pos_q <= p_q + POS_W'(1);
      OP_Q_END: begin
        pos_q <= pos_q + POS_W'(4);
        qd_q  <= qd_q - 16'd1;
      end
      OP_TYPE:          type_q <= sh_q[15:0];
      OP_TTL:           ttl_q <= sh_q;
      OP_RDLEN: begin
        rdlen_q <= sh_q[15:0];
        pos_q   <= pos_q + POS_W'(RR_FIXED);
      end
      OP_DEC_MX: begin
        pref_q    <= sh_q[15:0];
        p_q       <= pos_q + POS_W'(2);
        written_q <= '0;
        hops_q    <= '0;
        ci_q      <= '0;
        keep_q    <= 32'(total_q) < MAX_RECORDS;
        wslot_q   <= total_q;
      end
      OP_DEC_CN: begin
        p_q       <= pos_q;
        written_q <= '0;
        hops_q    <= '0;
        ci_q      <= '0;
        keep_q    <= 1'b1;
        wslot_q   <= RW'(MAX_RECORDS);
      end
      OP_PTR: begin
        hops_q <= hops_q + HW'(1);
        p_q    <= POS_W'({len_q[5:0], pkt_q});
      end
      OP_COPY_WR: begin
        written_q <= written_q + NLW'(1);
        ci_q      <= ci_q + 8'd1;
      end
      OP_DOT: begin
        written_q <= written_q + NLW'(1);
        ci_q      <= '0;
        p_q       <= p_q + POS_W'(len_q) + POS_W'(1);
      end
      OP_DEC_END:       wlen_q <= (written_q == '0) ? NLW'(1) : written_q;
      OP_EMIT_MX: begin
        pos_q      <= pos_q + POS_W'(rdlen_q);
        an_q       <= an_q - 16'd1;
        kind_q     <= KIND_MX;
        pref_out_q <= pref_q;
        ttl_out_q  <= ttl_q;
        nlen_q     <= 9'(wlen_q);
        slot_q     <= 5'(wslot_q);
        status_q   <= ST_OK;
        nbyte_q    <= 8'h00;
        last_q     <= 1'b0;
      end
      OP_EMIT_CN: begin
        kind_q     <= KIND_CNAME;
        pref_out_q <= 16'h0000;
        ttl_out_q  <= ttl_q;
        nlen_q     <= 9'(wlen_q);
        slot_q     <= 5'(MAX_RECORDS);
        status_q   <= ST_OK;
        nbyte_q    <= 8'h00;
        last_q     <= 1'b0;
      end
      OP_FINISH: begin
        kind_q     <= KIND_STATUS;
        pref_out_q <= 16'h0000;
        ttl_out_q  <= 32'h0;
        nlen_q     <= 9'h000;
        slot_q     <= 5'h00;
        status_q   <= cmd_i.st;
        nbyte_q    <= 8'h00;
        last_q     <= 1'b1;
      end
      OP_NAME_RD: begin
        rsel_q <= record_select_i;
        rlen_q <= sel_ok ? lengths_q[RW'(record_select_i)] : '0;
        rok_q  <= sel_ok && (12'(char_index_i) < 12'(lengths_q[RW'(record_select_i)]));
      end
      OP_NAME_OUT: begin
        kind_q     <= KIND_BYTE;
        pref_out_q <= 16'h0000;
        ttl_out_q  <= 32'h0;
        nlen_q     <= 9'(rlen_q);
        slot_q     <= rsel_q;
        status_q   <= ST_OK;
        nbyte_q    <= rok_q ? nm_q : 8'h00;
        last_q     <= 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    flags_o.short_pkt   = cnt_q < CW'(HEADER_LEN);
    flags_o.rcode_bad   = pkt_q[3:0] != 4'h0;
    flags_o.an_hdr_zero = sh_q[15:0] == 16'h0000;
    flags_o.qd_zero     = qd_q == 16'h0000;
    flags_o.an_zero     = an_q == 16'h0000;
    flags_o.p_ge_n      = p_q >= n;
    flags_o.p1_ge_n     = (p_q + POS_W'(1)) >= n;
    flags_o.p2_ge_n     = (p_q + POS_W'(2)) >= n;
    flags_o.top_ptr     = pkt_q[7:6] == 2'b11;
    flags_o.top_bad     = pkt_q[7:6] != 2'b00;
    flags_o.byte_zero   = pkt_q == 8'h00;
    flags_o.pos4_ge_n   = (pos_q + POS_W'(4)) >= n;
    flags_o.pos10_ge_n  = (pos_q + POS_W'(RR_FIXED)) >= n;
    flags_o.mx_bad      = ((pos_q + POS_W'(rdlen_q)) > n) || (rdlen_q < 16'd3);
    flags_o.type_mx     = type_q == TYPE_MX;
    flags_o.type_cname  = type_q == TYPE_CNAME;
    flags_o.hops_over   = 32'(hops_q) >= MAX_HOPS;
    flags_o.label_bad   = ((p_q + POS_W'(pkt_q)) >= n) ||
                          ((12'(written_q) + 12'(pkt_q) + 12'd1) >= 12'(NAME_BYTES));
    flags_o.copy_last   = (ci_q + 8'd1) == len_q;
  end

  assign result_valid_o = strobe_q;
  assign kind_o         = kind_q;
  assign preference_o   = pref_out_q;
  assign ttl_o          = ttl_out_q;
  assign name_length_o  = nlen_q;
  assign slot_o         = slot_q;
  assign status_o       = status_q;
  assign name_byte_o    = nbyte_q;
  assign last_o         = last_q;

endmodule

// ----- design/dmx_ctrl.sv -----
// dmx_ctrl: command decode and parse sequencer for the DNS MX answer parser.
// Drives dmx_pkg::cmd_t to dmx_datapath and steers on dmx_pkg::flags_t.
module dmx_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [1:0]      command_i,
  input  dmx_pkg::flags_t flags_i,
  output dmx_pkg::cmd_t   cmd_o,
  output logic            busy_o
);
  import dmx_pkg::*;

  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_N_OUT   = 6'd1;
  localparam logic [5:0] S_H_CHK   = 6'd2;
  localparam logic [5:0] S_H_RC    = 6'd3;
  localparam logic [5:0] S_H4      = 6'd4;
  localparam logic [5:0] S_H5      = 6'd5;
  localparam logic [5:0] S_H6      = 6'd6;
  localparam logic [5:0] S_H7      = 6'd7;
  localparam logic [5:0] S_H8      = 6'd8;
  localparam logic [5:0] S_Q_LOOP  = 6'd9;
  localparam logic [5:0] S_A_LOOP  = 6'd10;
  localparam logic [5:0] S_SK_CHK  = 6'd11;
  localparam logic [5:0] S_SK_LEN  = 6'd12;
  localparam logic [5:0] S_SK_ADV  = 6'd13;
  localparam logic [5:0] S_SK_DONE = 6'd14;
  localparam logic [5:0] S_R0      = 6'd15;
  localparam logic [5:0] S_R1      = 6'd16;
  localparam logic [5:0] S_R2      = 6'd17;
  localparam logic [5:0] S_R3      = 6'd18;
  localparam logic [5:0] S_R4      = 6'd19;
  localparam logic [5:0] S_R5      = 6'd20;
  localparam logic [5:0] S_R6      = 6'd21;
  localparam logic [5:0] S_R7      = 6'd22;
  localparam logic [5:0] S_R8      = 6'd23;
  localparam logic [5:0] S_R9      = 6'd24;
  localparam logic [5:0] S_P0      = 6'd25;
  localparam logic [5:0] S_P1      = 6'd26;
  localparam logic [5:0] S_P2      = 6'd27;
  localparam logic [5:0] S_D_CHK   = 6'd28;
  localparam logic [5:0] S_D_LEN   = 6'd29;
  localparam logic [5:0] S_D_PTR   = 6'd30;
  localparam logic [5:0] S_C_WR    = 6'd31;
  localparam logic [5:0] S_C_DOT   = 6'd32;
  localparam logic [5:0] S_D_EMIT  = 6'd33;
  localparam logic [5:0] S_FIN0    = 6'd34;

  logic [5:0] state_q, state_d;
  logic       in_ans_q, in_ans_d;
  logic [2:0] skip_err;

  assign skip_err = in_ans_q ? ST_BAD_ANS : ST_BAD_QUEST;
  assign busy_o   = state_q != S_IDLE;

  always_comb begin
    state_d  = state_q;
    in_ans_d = in_ans_q;
    cmd_o    = '{op: OP_NONE, shift: 1'b0, base: BASE_ZERO, off: 4'd0, st: ST_OK};
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (command_i)
            CMD_LOAD: cmd_o.op = OP_LOAD;
            CMD_PARSE: begin
              cmd_o.op = OP_INIT;
              in_ans_d = 1'b0;
              state_d  = S_H_CHK;
            end
            CMD_READ: begin
              cmd_o.op = OP_NAME_RD;
              state_d  = S_N_OUT;
            end
            default: ;
          endcase
        end
      end
      S_N_OUT: begin
        cmd_o.op = OP_NAME_OUT;
        state_d  = S_IDLE;
      end
      S_H_CHK: begin
        if (flags_i.short_pkt) begin
          cmd_o.op = OP_FINISH;
          cmd_o.st = ST_SHORT;
          state_d  = S_IDLE;
        end else begin
          cmd_o.off = 4'd3;
          state_d   = S_H_RC;
        end
      end
      S_H_RC: begin
        if (flags_i.rcode_bad) begin
          cmd_o.op = OP_FINISH;
          cmd_o.st = ST_RCODE;
          state_d  = S_IDLE;
        end else begin
          cmd_o.off = 4'd4;
          state_d   = S_H4;
        end
      end
      S_H4: begin
        cmd_o.shift = 1'b1;
        cmd_o.off   = 4'd5;
        state_d     = S_H5;
      end
      S_H5: begin
        cmd_o.shift = 1'b1;
        cmd_o.off   = 4'd6;
        state_d     = S_H6;
      end
      S_H6: begin
        cmd_o.shift = 1'b1;
        cmd_o.off   = 4'd7;
        state_d     = S_H7;
      end
      S_H7: begin
        cmd_o.shift = 1'b1;
        state_d     = S_H8;
      end
      S_H8: begin
        if (flags_i.an_hdr_zero) begin
          cmd_o.op = OP_FINISH;
          cmd_o.st = ST_NO_ANS;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = OP_SET_CNT;
          state_d  = S_Q_LOOP;
        end
      end
      S_Q_LOOP: begin
        if (flags_i.qd_zero) begin
          state_d = S_A_LOOP;
        end else begin
          cmd_o.op = OP_SKIP_BEGIN;
          state_d  = S_SK_CHK;
        end
      end
      S_A_LOOP: begin
        if (flags_i.an_zero) begin
          cmd_o.op = OP_FINISH;
          cmd_o.st = ST_OK;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = OP_SKIP_BEGIN;
          in_ans_d = 1'b1;
          state_d  = S_SK_CHK;
        end
      end
      S_SK_CHK: begin
        if (flags_i.p_ge_n) begin
          cmd_o.op = OP_FINISH;
          cmd_o.st = skip_err;
          state_d  = S_IDLE;
        end else begin
          cmd_o.base = BASE_P;
          state_d    = S_SK_LEN;
        end
      end
      S_SK_LEN: begin
        priority if (flags_i.top_ptr) begin
          if (flags_i.p2_ge_n) begin
            cmd_o.op = OP_FINISH;
            cmd_o.st = skip_err;
            state_d  = S_IDLE;
          end else begin
            cmd_o.op = OP_SKIP_PTR_END;
            state_d  = S_SK_DONE;
          end
        end else if (flags_i.top_bad) begin
          cmd_o.op = OP_FINISH;
          cmd_o.st = skip_err;
          state_d  = S_IDLE;
        end else if (flags_i.byte_zero) begin
          if (flags_i.p1_ge_n) begin
            cmd_o.op = OP_FINISH;
            cmd_o.st = skip_err;
            state_d  = S_IDLE;
          end else begin
            cmd_o.op = OP_SKIP_ZERO_END;
            state_d  = S_SK_DONE;
          end
        end else begin
          cmd_o.op = OP_LEN;
          state_d  = S_SK_ADV;
        end
      end
      S_SK_ADV: begin
        cmd_o.op = OP_SKIP_NEXT;
        state_d  = S_SK_CHK;
      end
      S_SK_DONE: begin
        if (!in_ans_q) begin
          if (flags_i.pos4_ge_n) begin
            cmd_o.op = OP_FINISH;
            cmd_o.st = ST_BAD_QUEST;
            state_d  = S_IDLE;
          end else begin
            cmd_o.op = OP_Q_END;
            state_d  = S_Q_LOOP;
          end
        end else if (flags_i.pos10_ge_n) begin
          cmd_o.op = OP_FINISH;
          cmd_o.st = ST_BAD_ANS;
          state_d  = S_IDLE;
        end else begin
          cmd_o.base = BASE_POS;
          state_d    = S_R0;
        end
      end
      S_R0: begin
        cmd_o.shift = 1'b1;
        cmd_o.base  = BASE_POS;
        cmd_o.off   = 4'd1;
        state_d     = S_R1;
      end
      S_R1: begin
        cmd_o.shift = 1'b1;
        cmd_o.base  = BASE_POS;
        cmd_o.off   = 4'd4;
        state_d     = S_R2;
      end
      S_R2: begin
        cmd_o.op    = OP_TYPE;
        cmd_o.shift = 1'b1;
        cmd_o.base  = BASE_POS;
        cmd_o.off   = 4'd5;
        state_d     = S_R3;
      end
      S_R3: begin
        cmd_o.shift = 1'b1;
        cmd_o.base  = BASE_POS;
        cmd_o.off   = 4'd6;
        state_d     = S_R4;
      end
      S_R4: begin
        cmd_o.shift = 1'b1;
        cmd_o.base  = BASE_POS;
        cmd_o.off   = 4'd7;
        state_d     = S_R5;
      end
      S_R5: begin
        cmd_o.shift = 1'b1;
        cmd_o.base  = BASE_POS;
        cmd_o.off   = 4'd8;
        state_d     = S_R6;
      end
      S_R6: begin
        cmd_o.op    = OP_TTL;
        cmd_o.shift = 1'b1;
        cmd_o.base  = BASE_POS;
        cmd_o.off   = 4'd9;
        state_d     = S_R7;
      end
      S_R7: begin
        cmd_o.shift = 1'b1;
        state_d     = S_R8;
      end
      S_R8: begin
        cmd_o.op = OP_RDLEN;
        state_d  = S_R9;
      end
      S_R9: begin
        priority if (flags_i.type_mx) begin
          if (flags_i.mx_bad) begin
            cmd_o.op = OP_FINISH;
            cmd_o.st = ST_BAD_ANS;
            state_d  = S_IDLE;
          end else begin
            cmd_o.base = BASE_POS;
            state_d    = S_P0;
          end
        end else if (flags_i.type_cname) begin
          cmd_o.op = OP_DEC_CN;
          state_d  = S_D_CHK;
        end else begin
          cmd_o.op = OP_FINISH;
          cmd_o.st = ST_OTHER;
          state_d  = S_IDLE;
        end
      end
      S_P0: begin
        cmd_o.shift = 1'b1;
        cmd_o.base  = BASE_POS;
        cmd_o.off   = 4'd1;
        state_d     = S_P1;
      end
      S_P1: begin
        cmd_o.shift = 1'b1;
        state_d     = S_P2;
      end
      S_P2: begin
        cmd_o.op = OP_DEC_MX;
        state_d  = S_D_CHK;
      end
      S_D_CHK: begin
        if (flags_i.p_ge_n) begin
          cmd_o.op = OP_FINISH;
          cmd_o.st = ST_NAME_ERR;
          state_d  = S_IDLE;
        end else begin
          cmd_o.base = BASE_P;
          state_d    = S_D_LEN;
        end
      end
      S_D_LEN: begin
        priority if (flags_i.top_ptr) begin
          if (flags_i.p1_ge_n || flags_i.hops_over) begin
            cmd_o.op = OP_FINISH;
            cmd_o.st = ST_NAME_ERR;
            state_d  = S_IDLE;
          end else begin
            cmd_o.op   = OP_LEN;
            cmd_o.base = BASE_P;
            cmd_o.off  = 4'd1;
            state_d    = S_D_PTR;
          end
        end else if (flags_i.top_bad) begin
          cmd_o.op = OP_FINISH;
          cmd_o.st = ST_NAME_ERR;
          state_d  = S_IDLE;
        end else if (flags_i.byte_zero) begin
          cmd_o.op = OP_DEC_END;
          state_d  = S_D_EMIT;
        end else if (flags_i.label_bad) begin
          cmd_o.op = OP_FINISH;
          cmd_o.st = ST_NAME_ERR;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op   = OP_LEN;
          cmd_o.base = BASE_COPY;
          state_d    = S_C_WR;
        end
      end
      S_D_PTR: begin
        cmd_o.op = OP_PTR;
        state_d  = S_D_CHK;
      end
      S_C_WR: begin
        cmd_o.op   = OP_COPY_WR;
        cmd_o.base = BASE_COPY;
        cmd_o.off  = 4'd1;
        state_d    = flags_i.copy_last ? S_C_DOT : S_C_WR;
      end
      S_C_DOT: begin
        cmd_o.op = OP_DOT;
        state_d  = S_D_CHK;
      end
      S_D_EMIT: begin
        if (flags_i.type_mx) begin
          cmd_o.op = OP_EMIT_MX;
          state_d  = S_A_LOOP;
        end else begin
          cmd_o.op = OP_EMIT_CN;
          state_d  = S_FIN0;
        end
      end
      S_FIN0: begin
        cmd_o.op = OP_FINISH;
        cmd_o.st = ST_OK;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      in_ans_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      in_ans_q <= in_ans_d;
    end
  end

endmodule

// ----- design/dns_mx_answer_parser.sv -----
// DNS MX answer parser, top level. A word is taken when start_i is high and
// busy_o is low. command_i selects: load one packet byte, parse the loaded
// packet, or read one byte of a stored name (record_select_i, char_index_i).
// A load gives no result and keeps busy_o low. A name read registers its
// lookup, then its output word, and gives one result; busy_o is high while
// the output word is formed. A parse emits one word per MX record kept, a
// CNAME word if one is met, and always a final status word with last_o set;
// each result is on the output ports for one cycle with result_valid_o high,
// and cannot be stalled. Parse time depends on the packet (one registered
// packet-memory read port serves every access): header checks; per question
// its name skip; per MX or CNAME answer its fixed fields, name skip and name
// decode; the final status after the last answer. A name skip steps label by
// label to its end; a decode steps through each pointer and copies each label
// byte by byte, so its time grows with label length. Busy stays high until
// the final status is registered.
// Reset clears the byte count, record total and stored name lengths; the
// packet and name memories are not cleared.
// Depends on dmx_pkg, dmx_ctrl and dmx_datapath.
module dns_mx_answer_parser #(
  parameter int unsigned PACKET_BYTES     = dmx_pkg::PACKET_BYTES_DEF,
  parameter int unsigned NAME_BYTES       = dmx_pkg::NAME_BYTES_DEF,
  parameter int unsigned MAX_RECORDS      = dmx_pkg::MAX_RECORDS_DEF,
  parameter int unsigned MAX_POINTER_HOPS = dmx_pkg::MAX_HOPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  packet_byte_i,
  input  logic [4:0]  record_select_i,
  input  logic [7:0]  char_index_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [15:0] preference_o,
  output logic [31:0] ttl_o,
  output logic [8:0]  name_length_o,
  output logic [4:0]  slot_o,
  output logic [2:0]  status_o,
  output logic [7:0]  name_byte_o,
  output logic        last_o
);
  import dmx_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  dmx_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .command_i(command_i),
    .flags_i  (flags),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  dmx_datapath #(
    .PACKET_BYTES(PACKET_BYTES),
    .NAME_BYTES  (NAME_BYTES),
    .MAX_RECORDS (MAX_RECORDS),
    .MAX_HOPS    (MAX_POINTER_HOPS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .flags_o        (flags),
    .packet_byte_i  (packet_byte_i),
    .record_select_i(record_select_i),
    .char_index_i   (char_index_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .preference_o   (preference_o),
    .ttl_o          (ttl_o),
    .name_length_o  (name_length_o),
    .slot_o         (slot_o),
    .status_o       (status_o),
    .name_byte_o    (name_byte_o),
    .last_o         (last_o)
  );

endmodule
